// ===== sv/cau_pkg.sv =====
// Shared types, constants and helper functions of the complex arithmetic unit.
// Used by every module of the block; depends on nothing else.
package cau_pkg;

   localparam int DataWidth       = 32;
   localparam int FracBitsDefault = 16;
   localparam int WideWidth       = 2 * DataWidth;
   localparam int NumWidth        = 3 * DataWidth;

   typedef logic [DataWidth-1:0] word_type;
   typedef logic [WideWidth-1:0] wide_type;

   typedef enum logic [1:0] {
      KindAdd = 2'd0,
      KindSub = 2'd1,
      KindMul = 2'd2,
      KindDiv = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      StatusOk      = 2'd0,
      StatusSat     = 2'd1,
      StatusDivZero = 2'd2
   } status_type;

   typedef struct packed {
      kind_type kind;
      word_type a_real;
      word_type a_imag;
      word_type b_real;
      word_type b_imag;
   } req_type;

   typedef struct packed {
      word_type   res_real;
      word_type   res_imag;
      status_type status;
   } rsp_type;

   // Sign-magnitude value at product width
   typedef struct packed {
      logic     neg;
      wide_type mag;
   } smag_type;

   // Saturated part and its overflow flag
   typedef struct packed {
      word_type val;
      logic     sat;
   } sat_type;

   // Item state inside the divider chain; non-divide items carry their final magnitude in q
   typedef struct packed {
      logic     is_div;
      logic     zero;
      logic     ovf_r;
      logic     ovf_i;
      logic     neg_r;
      logic     neg_i;
      wide_type den;
      wide_type rem_r;
      wide_type rem_i;
      word_type low_r;
      word_type low_i;
      word_type q_r;
      word_type q_i;
   } div_type;

   // Signed sum of two sign-magnitude values; zero is always positive
   function automatic smag_type sm_add(input logic s1, input wide_type m1,
                                       input logic s2, input wide_type m2);
      smag_type         r;
      logic [WideWidth:0] diff;
      diff = {1'b0, m1} - {1'b0, m2};
      if (s1 == s2) begin
         r.neg = s1;
         r.mag = m1 + m2;
      end else if (!diff[WideWidth]) begin
         r.neg = s1;
         r.mag = diff[WideWidth-1:0];
      end else begin
         r.neg = s2;
         r.mag = m2 - m1;
      end
      if (r.mag == '0) begin
         r.neg = 1'b0;
      end
      return r;
   endfunction

   // Clamp a sign-magnitude part to the two's complement word range
   function automatic sat_type saturate(input logic neg, input word_type q);
      sat_type r;
      if (!neg || q == '0) begin
         r.sat = q[DataWidth-1];
         r.val = r.sat ? {1'b0, {(DataWidth-1){1'b1}}} : q;
      end else begin
         r.sat = q[DataWidth-1] && (q[DataWidth-2:0] != '0);
         r.val = r.sat ? {1'b1, {(DataWidth-1){1'b0}}} : word_type'(~q + word_type'(1));
      end
      return r;
   endfunction

endpackage

// ===== sv/cau_front.sv =====
// Front end of the complex arithmetic unit: operand split, products, signed sums
// and divider setup in four register stages. Depends on cau_pkg.
module cau_front #(
   parameter int FRAC_BITS = cau_pkg::FracBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cau_pkg::req_type req_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cau_pkg::div_type out_data
);
   import cau_pkg::*;

   // stage valids and readies
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   // stage 1: signs and magnitudes (0 a_real, 1 a_imag, 2 b_real, 3 b_imag)
   kind_type                      s1_kind_ff;
   logic [3:0]                    s1_neg_ff, s1_neg_in;
   logic [3:0][DataWidth-1:0]     s1_mag_ff, s1_mag_in;
   word_type [3:0]                ops;

   // stage 2: products ac, bd, ad, bc, cc, dd
   kind_type                      s2_kind_ff;
   logic [3:0]                    s2_neg_ff;
   logic [3:0][DataWidth-1:0]     s2_mag_ff;
   logic [5:0][WideWidth-1:0]     s2_prod_ff, s2_prod_in;

   // stage 3: signed sums and divisor
   kind_type                      s3_kind_ff;
   smag_type                      s3_re_ff, s3_re_in, s3_im_ff, s3_im_in;
   wide_type                      s3_den_ff, s3_den_in;

   // stage 4: divider setup
   div_type                       s4_data_ff, s4_data_in;

   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // split operands into sign and magnitude
   assign ops = {req_data.b_imag, req_data.b_real, req_data.a_imag, req_data.a_real};
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s1_neg_in[k] = ops[k][DataWidth-1];
         s1_mag_in[k] = ops[k][DataWidth-1] ? word_type'(~ops[k] + word_type'(1)) : ops[k];
      end
   end

   // form the six magnitude products
   always_comb begin
      s2_prod_in[0] = wide_type'(s1_mag_ff[0]) * wide_type'(s1_mag_ff[2]);
      s2_prod_in[1] = wide_type'(s1_mag_ff[1]) * wide_type'(s1_mag_ff[3]);
      s2_prod_in[2] = wide_type'(s1_mag_ff[0]) * wide_type'(s1_mag_ff[3]);
      s2_prod_in[3] = wide_type'(s1_mag_ff[1]) * wide_type'(s1_mag_ff[2]);
      s2_prod_in[4] = wide_type'(s1_mag_ff[2]) * wide_type'(s1_mag_ff[2]);
      s2_prod_in[5] = wide_type'(s1_mag_ff[3]) * wide_type'(s1_mag_ff[3]);
   end

   // combine parts by operation
   always_comb begin
      logic s_ac, s_bd, s_ad, s_bc;
      s_ac = s2_neg_ff[0] ^ s2_neg_ff[2];
      s_bd = s2_neg_ff[1] ^ s2_neg_ff[3];
      s_ad = s2_neg_ff[0] ^ s2_neg_ff[3];
      s_bc = s2_neg_ff[1] ^ s2_neg_ff[2];
      s3_den_in = s2_prod_ff[4] + s2_prod_ff[5];
      unique case (s2_kind_ff)
         KindAdd: begin
            s3_re_in = sm_add(s2_neg_ff[0], wide_type'(s2_mag_ff[0]),
                              s2_neg_ff[2], wide_type'(s2_mag_ff[2]));
            s3_im_in = sm_add(s2_neg_ff[1], wide_type'(s2_mag_ff[1]),
                              s2_neg_ff[3], wide_type'(s2_mag_ff[3]));
         end
         KindSub: begin
            s3_re_in = sm_add(s2_neg_ff[0], wide_type'(s2_mag_ff[0]),
                              !s2_neg_ff[2] && (s2_mag_ff[2] != '0),
                              wide_type'(s2_mag_ff[2]));
            s3_im_in = sm_add(s2_neg_ff[1], wide_type'(s2_mag_ff[1]),
                              !s2_neg_ff[3] && (s2_mag_ff[3] != '0),
                              wide_type'(s2_mag_ff[3]));
         end
         KindMul: begin
            s3_re_in = sm_add(s_ac, s2_prod_ff[0], !s_bd, s2_prod_ff[1]);
            s3_im_in = sm_add(s_ad, s2_prod_ff[2], s_bc, s2_prod_ff[3]);
         end
         KindDiv: begin
            s3_re_in = sm_add(s_ac, s2_prod_ff[0], s_bd, s2_prod_ff[1]);
            s3_im_in = sm_add(s_bc, s2_prod_ff[3], !s_ad, s2_prod_ff[2]);
         end
         default: begin
            s3_re_in = '0;
            s3_im_in = '0;
         end
      endcase
   end

   // set up divider state, or finish the magnitude of other operations
   always_comb begin
      logic [NumWidth-1:0]  num_r, num_i;
      wide_type             sh_r, sh_i;
      num_r = {{DataWidth{1'b0}}, s3_re_ff.mag} << FRAC_BITS;
      num_i = {{DataWidth{1'b0}}, s3_im_ff.mag} << FRAC_BITS;
      sh_r  = s3_re_ff.mag >> FRAC_BITS;
      sh_i  = s3_im_ff.mag >> FRAC_BITS;
      s4_data_in        = '0;
      s4_data_in.neg_r  = s3_re_ff.neg;
      s4_data_in.neg_i  = s3_im_ff.neg;
      s4_data_in.den    = s3_den_ff;
      unique case (s3_kind_ff)
         KindDiv: begin
            s4_data_in.is_div = 1'b1;
            s4_data_in.zero   = (s3_den_ff == '0);
            s4_data_in.ovf_r  = num_r[NumWidth-1:DataWidth] >= s3_den_ff;
            s4_data_in.ovf_i  = num_i[NumWidth-1:DataWidth] >= s3_den_ff;
            s4_data_in.rem_r  = s4_data_in.ovf_r ? '0 : num_r[NumWidth-1:DataWidth];
            s4_data_in.rem_i  = s4_data_in.ovf_i ? '0 : num_i[NumWidth-1:DataWidth];
            s4_data_in.low_r  = num_r[DataWidth-1:0];
            s4_data_in.low_i  = num_i[DataWidth-1:0];
         end
         KindMul: begin
            s4_data_in.q_r = (sh_r[WideWidth-1:DataWidth] != '0) ? '1 : sh_r[DataWidth-1:0];
            s4_data_in.q_i = (sh_i[WideWidth-1:DataWidth] != '0) ? '1 : sh_i[DataWidth-1:0];
         end
         KindAdd, KindSub: begin
            s4_data_in.q_r = (s3_re_ff.mag[WideWidth-1:DataWidth] != '0) ? '1
                             : s3_re_ff.mag[DataWidth-1:0];
            s4_data_in.q_i = (s3_im_ff.mag[WideWidth-1:DataWidth] != '0) ? '1
                             : s3_im_ff.mag[DataWidth-1:0];
         end
         default: begin
            s4_data_in.q_r = '0;
         end
      endcase
   end

   // load payload registers where a stage advances
   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_kind_ff <= req_data.kind;
         s1_neg_ff  <= s1_neg_in;
         s1_mag_ff  <= s1_mag_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_kind_ff <= s1_kind_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_mag_ff  <= s1_mag_ff;
         s2_prod_ff <= s2_prod_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_kind_ff <= s2_kind_ff;
         s3_re_ff   <= s3_re_in;
         s3_im_ff   <= s3_im_in;
         s3_den_ff  <= s3_den_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
   end

endmodule

// ===== sv/cau_div_step.sv =====
// One restoring-division stage of the complex arithmetic unit: one quotient bit
// of each part per stage. Depends on cau_pkg.
module cau_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cau_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cau_pkg::div_type out_data
);
   import cau_pkg::*;

   logic    valid_ff;
   div_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // shift in the next numerator bit and try the divisor
   always_comb begin
      logic [WideWidth:0] trial_r, trial_i, den_x;
      logic               ge_r, ge_i;
      den_x   = {1'b0, in_data.den};
      trial_r = {in_data.rem_r, in_data.low_r[DataWidth-1]};
      trial_i = {in_data.rem_i, in_data.low_i[DataWidth-1]};
      ge_r    = trial_r >= den_x;
      ge_i    = trial_i >= den_x;
      data_in = in_data;
      if (in_data.is_div) begin
         data_in.rem_r = ge_r ? wide_type'(trial_r - den_x) : trial_r[WideWidth-1:0];
         data_in.rem_i = ge_i ? wide_type'(trial_i - den_x) : trial_i[WideWidth-1:0];
         data_in.low_r = {in_data.low_r[DataWidth-2:0], 1'b0};
         data_in.low_i = {in_data.low_i[DataWidth-2:0], 1'b0};
         data_in.q_r   = {in_data.q_r[DataWidth-2:0], ge_r};
         data_in.q_i   = {in_data.q_i[DataWidth-2:0], ge_i};
      end
   end

   // advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   // a live divide keeps its partial remainder below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.is_div && !data_ff.ovf_r && !data_ff.ovf_i |->
         data_ff.rem_r < data_ff.den && data_ff.rem_i < data_ff.den)
      else $error("partial remainder not below divisor");

endmodule

// ===== sv/cau_back.sv =====
// Back end of the complex arithmetic unit: saturation, status and the result
// register. Depends on cau_pkg.
module cau_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cau_pkg::div_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   logic    valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign in_ready  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   // clamp both parts and pick the status
   always_comb begin
      word_type q_r, q_i;
      sat_type  sat_r, sat_i;
      q_r   = (in_data.is_div && in_data.ovf_r) ? '1 : in_data.q_r;
      q_i   = (in_data.is_div && in_data.ovf_i) ? '1 : in_data.q_i;
      sat_r = saturate(in_data.neg_r, q_r);
      sat_i = saturate(in_data.neg_i, q_i);
      if (in_data.is_div && in_data.zero) begin
         rsp_in.res_real = '0;
         rsp_in.res_imag = '0;
         rsp_in.status   = StatusDivZero;
      end else begin
         rsp_in.res_real = sat_r.val;
         rsp_in.res_imag = sat_i.val;
         rsp_in.status   = (sat_r.sat || sat_i.sat) ? StatusSat : StatusOk;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// operands in signed fixed point (FRAC_BITS fraction bits in 32-bit words).
// Depends on cau_pkg, cau_front, cau_div_step and cau_back.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) carries kind and both operands;
//    rsp channel (rsp_valid/rsp_ready/rsp_data) returns the result and status.
//  - Every item passes 37 register stages: four front stages (split, multiply,
//    sum, divider setup), one stage per quotient bit in the 32-stage divider
//    chain, and the result register. All kinds see the same latency, so
//    results leave in order.
//  - Throughput is one item per cycle unless the receiver stalls; the
//    divider chain is fully pipelined.
//  - Products and quotients truncate toward zero; parts out of range saturate
//    with status 1; a zero divisor returns zero with status 2.
//  - When the receiver stalls, items close up into empty stages and req_ready
//    falls only once every stage holds an item.
//  - Reset empties the pipeline; no result is pending afterwards.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FracBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   logic [DataWidth:0] chain_valid;
   logic [DataWidth:0] chain_ready;
   div_type            chain_data [DataWidth+1];

   // operand split, products and divider setup
   cau_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // one quotient bit per stage
   for (genvar g = 0; g < DataWidth; g++) begin : g_div
      cau_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // saturation and result register
   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[DataWidth]),
      .in_ready  (chain_ready[DataWidth]),
      .in_data   (chain_data[DataWidth]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_divzero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == StatusDivZero |->
         rsp_data.res_real == '0 && rsp_data.res_imag == '0)
      else $error("divide by zero result not cleared");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == StatusSat |->
         rsp_data.res_real == {1'b0, {(DataWidth-1){1'b1}}} ||
         rsp_data.res_real == {1'b1, {(DataWidth-1){1'b0}}} ||
         rsp_data.res_imag == {1'b0, {(DataWidth-1){1'b1}}} ||
         rsp_data.res_imag == {1'b1, {(DataWidth-1){1'b0}}})
      else $error("saturated status without a part at a limit");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for complex_arithmetic_unit: drives operand items,
// predicts each result in fixed point and checks it. Depends on cau_pkg and complex_arithmetic_unit.
module tb_top;
   import cau_pkg::*;

   localparam int StallLimit = 20000;
   localparam int DrainCycles = 60;
   localparam logic [63:0] WordMax = 64'h7fff_ffff;
   localparam logic [63:0] WordMinMag = 64'h8000_0000;

   // Scoreboard: predicts results from accepted items and checks outputs
   class arith_book;
      rsp_type results_due[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         $display("mismatch %s: got %h want %h", what, got, want);
         errors++;
      endtask

      function automatic void split(input word_type w, output logic neg,
                                    output logic [63:0] mag);
         neg = w[31];
         mag = neg ? {32'b0, word_type'(~w + 32'd1)} : {32'b0, w};
      endfunction

      function automatic void sum_sm(input logic s1, input logic [63:0] m1,
                                     input logic s2, input logic [63:0] m2,
                                     output logic s, output logic [63:0] m);
         if (s1 == s2) begin
            s = s1; m = m1 + m2;
         end else if (m1 >= m2) begin
            s = s1; m = m1 - m2;
         end else begin
            s = s2; m = m2 - m1;
         end
         if (m == 0) s = 1'b0;
      endfunction

      function automatic word_type clamp(input logic neg, input logic [63:0] mag,
                                         inout logic sat);
         if (!neg) begin
            if (mag > WordMax) begin
               sat = 1'b1; mag = WordMax;
            end
            return mag[31:0];
         end
         if (mag > WordMinMag) begin
            sat = 1'b1; mag = WordMinMag;
         end
         return word_type'(~mag[31:0] + 32'd1);
      endfunction

      // Quotient of (mag << 16) / den; all ones when it exceeds 64 bits
      function automatic logic [63:0] frac_div(input logic [63:0] mag,
                                               input logic [63:0] den);
         logic [127:0] q;
         q = ({64'b0, mag} << FracBitsDefault) / {64'b0, den};
         return (q[127:64] != 0) ? '1 : q[63:0];
      endfunction

      function automatic rsp_type predict_result(input req_type r);
         rsp_type o;
         logic sa, sb, sc, sd, sr, si, sat;
         logic [63:0] ma, mb, mc, md, mr, mi, den;
         sat = 1'b0;
         split(r.a_real, sa, ma);
         split(r.a_imag, sb, mb);
         split(r.b_real, sc, mc);
         split(r.b_imag, sd, md);
         case (r.kind)
            KindAdd: begin
               sum_sm(sa, ma, sc, mc, sr, mr);
               sum_sm(sb, mb, sd, md, si, mi);
            end
            KindSub: begin
               sum_sm(sa, ma, !sc && mc != 0, mc, sr, mr);
               sum_sm(sb, mb, !sd && md != 0, md, si, mi);
            end
            KindMul: begin
               sum_sm(sa != sc, ma * mc, !(sb != sd), mb * md, sr, mr);
               sum_sm(sa != sd, ma * md, sb != sc, mb * mc, si, mi);
               mr = mr >> FracBitsDefault;
               mi = mi >> FracBitsDefault;
            end
            default: begin
               den = mc * mc + md * md;
               if (den == 0) begin
                  o.res_real = '0;
                  o.res_imag = '0;
                  o.status = StatusDivZero;
                  return o;
               end
               sum_sm(sa != sc, ma * mc, sb != sd, mb * md, sr, mr);
               sum_sm(sb != sc, mb * mc, !(sa != sd), ma * md, si, mi);
               mr = frac_div(mr, den);
               mi = frac_div(mi, den);
            end
         endcase
         o.res_real = clamp(sr && mr != 0, mr, sat);
         o.res_imag = clamp(si && mi != 0, mi, sat);
         o.status = sat ? StatusSat : StatusOk;
         return o;
      endfunction

      function void note_item(input req_type r);
         results_due.push_back(predict_result(r));
      endfunction

      task check_result(input rsp_type got);
         rsp_type want;
         if (results_due.size() == 0) begin
            report("unexpected result", got.res_real, 0);
            return;
         end
         want = results_due.pop_front();
         if (got.res_real !== want.res_real) report("res_real", got.res_real, want.res_real);
         if (got.res_imag !== want.res_imag) report("res_imag", got.res_imag, want.res_imag);
         if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   arith_book book;
   bit calm;
   bit hold_rsp;
   int quiet_cycles;

   complex_arithmetic_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one item and hold it until accepted; returns at the accepting edge
   task send_item(input req_type r);
      req_data <= r;
      req_valid <= 1'b1;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      book.note_item(r);
      @(posedge clock);
   endtask

   // Drop valid now and then for a random idle stretch
   task maybe_idle();
      if (!calm && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic word_type rand_word();
      word_type corner[6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                              32'h0001_0000, 32'hffff_0000};
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return word_type'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
         2: return corner[$urandom_range(0, 5)];
         default: return word_type'($signed($urandom) >>> $urandom_range(4, 20));
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type r;
      r.kind = kind_type'($urandom_range(0, 3));
      r.a_real = rand_word();
      r.a_imag = rand_word();
      r.b_real = rand_word();
      r.b_imag = rand_word();
      if (r.kind == KindDiv && $urandom_range(0, 19) == 0) begin
         r.b_real = '0;
         r.b_imag = '0;
      end
      return r;
   endfunction

   function automatic req_type make_item(input kind_type k, input word_type ar,
                                         input word_type ai, input word_type br,
                                         input word_type bi);
      req_type r;
      r.kind = k; r.a_real = ar; r.a_imag = ai; r.b_real = br; r.b_imag = bi;
      return r;
   endfunction

   // Receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= reset ? 1'b0 : (calm || $urandom_range(0, 99) >= 6);
         @(negedge clock);
         if (rsp_valid && rsp_ready) book.check_result(rsp_data);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      quiet_cycles = 0;
      forever begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      req_type dir_items[$];
      book = new();
      calm = 1'b0;
      hold_rsp = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every kind, saturation and zero divisor
      dir_items.push_back(make_item(KindAdd, 32'h7fff_ffff, 32'h8000_0000,
                                    32'h0000_0001, 32'hffff_ffff));
      dir_items.push_back(make_item(KindAdd, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h8000_0000, 32'h7fff_ffff));
      dir_items.push_back(make_item(KindAdd, 32'h0001_8000, 32'hfffe_0000,
                                    32'h0002_0000, 32'h0002_0000));
      dir_items.push_back(make_item(KindSub, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h0000_0001, 32'hffff_ffff));
      dir_items.push_back(make_item(KindSub, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
      dir_items.push_back(make_item(KindSub, 32'h0003_0000, 32'h0001_0000,
                                    32'h0003_0000, 32'h0001_0000));
      dir_items.push_back(make_item(KindMul, 32'h0002_0000, 32'h0003_0000,
                                    32'h0004_0000, 32'hffff_0000));
      dir_items.push_back(make_item(KindMul, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000));
      dir_items.push_back(make_item(KindMul, 32'h7fff_ffff, 32'h8000_0000,
                                    32'h7fff_ffff, 32'h7fff_ffff));
      dir_items.push_back(make_item(KindMul, 32'hffff_ffff, 32'h0000_0001,
                                    32'h0000_0001, 32'hffff_ffff));
      dir_items.push_back(make_item(KindMul, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
      dir_items.push_back(make_item(KindDiv, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
      dir_items.push_back(make_item(KindDiv, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0));
      dir_items.push_back(make_item(KindDiv, 32'h0006_0000, 32'h0002_0000,
                                    32'h0002_0000, 32'h0));
      dir_items.push_back(make_item(KindDiv, 32'h0001_0000, 32'h0001_0000,
                                    32'h0001_0000, 32'hffff_0000));
      dir_items.push_back(make_item(KindDiv, 32'h7fff_ffff, 32'h7fff_ffff,
                                    32'h0000_0001, 32'h0));
      dir_items.push_back(make_item(KindDiv, 32'h8000_0000, 32'h8000_0000,
                                    32'h0, 32'hffff_ffff));
      dir_items.push_back(make_item(KindDiv, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h8000_0000, 32'h8000_0000));
      dir_items.push_back(make_item(KindDiv, 32'h0000_0001, 32'hffff_ffff,
                                    32'h7fff_ffff, 32'h7fff_ffff));
      foreach (dir_items[i]) begin
         send_item(dir_items[i]);
         maybe_idle();
      end

      // Random items; quiet stretch, receiver hold-off and a full drain on the way
      for (int n = 0; n < 1800; n++) begin
         calm = (n >= 600 && n < 900);
         if (n == 300) hold_rsp = 1'b1;
         if (n == 1200) begin
            req_valid <= 1'b0;
            while (book.results_due.size() != 0) @(posedge clock);
         end
         send_item(rand_item());
         maybe_idle();
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // Drain
      while (book.results_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (book.errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
